// File: hw/rtl/crc16_packet_deframer_core_defines.svh
// Assertion macros shared by the deframer checker.
`ifndef CRC16_PACKET_DEFRAMER_CORE_DEFINES_SVH
`define CRC16_PACKET_DEFRAMER_CORE_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define CPD_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CPD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/cpd_pkg.sv
// Types and constants of the CRC-16 packet deframer.
`default_nettype none

package cpd_pkg;

    localparam int DEF_MAX_PAYLOAD = 32;

    localparam logic [7:0]  SOP_BYTE      = 8'hA1;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    // CCITT polynomial 0x1021, bit-reversed for the LSB-first update.
    localparam logic [15:0] CRC_POLY_REFL = 16'h8408;

    localparam int M_TDATA_W = 32;

    typedef enum logic [2:0] {
        FR_HUNT    = 3'd0,
        FR_TYPE    = 3'd1,
        FR_LEN     = 3'd2,
        FR_CRCLO   = 3'd3,
        FR_CRCHI   = 3'd4,
        FR_PAYLOAD = 3'd5
    } frame_state_t;

    typedef enum logic [2:0] {
        SEQ_ACCEPT = 3'd0,
        SEQ_CRC    = 3'd1,
        SEQ_CHECK  = 3'd2,
        SEQ_READ   = 3'd3,
        SEQ_SEND   = 3'd4
    } seq_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/crc16_packet_deframer_core.sv
// Byte-stream packet deframer: start byte 0xA1, type, length, CRC-16 (MCRF4XX), payload.
// A start, CRC, hunting or rejected length byte is only taken; a type, accepted length or
// payload byte is taken and then run through the bit-serial CRC unit, which shifts one
// bit per cycle, before the next byte is accepted. A complete frame is then checked; on a
// CRC match it is sent out result by result, each through the registered payload buffer
// read and then the output register, where it stays until it is taken; no input is taken
// while the run is being sent.
`default_nettype none

module crc16_packet_deframer_core
    import cpd_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [7:0] rx_byte
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [7:0] packet_type, [13:8] packet_length, [18:14] byte_index,
    // [26:19] payload_byte, [31:27] zero
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic [0:0]                m_tuser,   // [0] has_payload
    output logic                      m_tlast
);

    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    seq_state_t   seq_reg, seq_next;
    frame_state_t frame_reg, frame_next;

    logic [7:0]       held_type_reg, held_type_next;
    logic [LEN_W-1:0] held_length_reg, held_length_next;
    logic [15:0]      received_crc_reg, received_crc_next;
    logic [15:0]      running_crc_reg, running_crc_next;
    logic [LEN_W-1:0] payload_count_reg, payload_count_next;
    logic [7:0]       shift_reg, shift_next;
    logic [2:0]       bit_cnt_reg, bit_cnt_next;
    logic [IDX_W-1:0] emit_idx_reg, emit_idx_next;
    logic [7:0]       rd_data_reg;

    logic [7:0] payload_mem [MAX_PAYLOAD];

    logic             in_fire;
    logic             out_fire;
    logic             is_sop;
    logic             len_ok;
    logic             frame_done;
    logic             crc_match;
    logic             out_last;
    logic             has_payload;
    logic             mem_we;
    logic             crc_fb;
    logic [LEN_W-1:0] idx_plus_one;
    logic [5:0]       idx_wide;

    assign in_fire      = s_tvalid && s_tready;
    assign out_fire     = m_tvalid && m_tready;
    assign is_sop       = (s_tdata == SOP_BYTE);
    assign len_ok       = ({1'b0, s_tdata} <= 9'(MAX_PAYLOAD));
    assign frame_done   = (frame_reg == FR_PAYLOAD) && (payload_count_reg >= held_length_reg);
    assign crc_match    = (running_crc_reg == received_crc_reg);
    assign has_payload  = (held_length_reg != '0);
    assign idx_plus_one = LEN_W'(emit_idx_reg) + LEN_W'(1);
    assign out_last     = !has_payload || (idx_plus_one == held_length_reg);
    assign crc_fb       = running_crc_reg[0] ^ shift_reg[0];
    assign mem_we       = in_fire && (frame_reg == FR_PAYLOAD)
                          && (payload_count_reg < LEN_W'(MAX_PAYLOAD));

    // Sequencer and frame state.
    always_comb begin
        seq_next   = seq_reg;
        frame_next = frame_reg;
        case (seq_reg)
            SEQ_ACCEPT: begin
                if (in_fire) begin
                    case (frame_reg)
                        FR_HUNT: begin
                            if (is_sop) begin
                                frame_next = FR_TYPE;
                            end
                        end
                        FR_TYPE: begin
                            frame_next = FR_LEN;
                            seq_next   = SEQ_CRC;
                        end
                        FR_LEN: begin
                            if (len_ok) begin
                                frame_next = FR_CRCLO;
                                seq_next   = SEQ_CRC;
                            end else begin
                                frame_next = FR_HUNT;
                            end
                        end
                        FR_CRCLO: begin
                            frame_next = FR_CRCHI;
                        end
                        FR_CRCHI: begin
                            if (!has_payload) begin
                                seq_next = SEQ_CHECK;
                            end else begin
                                frame_next = FR_PAYLOAD;
                            end
                        end
                        FR_PAYLOAD: begin
                            seq_next = SEQ_CRC;
                        end
                        default: begin
                            frame_next = is_sop ? FR_TYPE : FR_HUNT;
                        end
                    endcase
                end
            end
            SEQ_CRC: begin
                if (bit_cnt_reg == 3'd7) begin
                    seq_next = frame_done ? SEQ_CHECK : SEQ_ACCEPT;
                end
            end
            SEQ_CHECK: begin
                frame_next = FR_HUNT;
                seq_next   = crc_match ? SEQ_READ : SEQ_ACCEPT;
            end
            SEQ_READ: begin
                seq_next = SEQ_SEND;
            end
            SEQ_SEND: begin
                if (out_fire) begin
                    seq_next = out_last ? SEQ_ACCEPT : SEQ_READ;
                end
            end
            default: begin
                seq_next = SEQ_ACCEPT;
            end
        endcase
    end

    // Handshake outputs.
    always_comb begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        case (seq_reg)
            SEQ_ACCEPT: s_tready = 1'b1;
            SEQ_SEND:   m_tvalid = 1'b1;
            default: begin
                s_tready = 1'b0;
                m_tvalid = 1'b0;
            end
        endcase
    end

    // Datapath: header capture, payload count, output index and the shared bit-serial CRC unit.
    always_comb begin
        held_type_next     = held_type_reg;
        held_length_next   = held_length_reg;
        received_crc_next  = received_crc_reg;
        running_crc_next   = running_crc_reg;
        payload_count_next = payload_count_reg;
        shift_next         = shift_reg;
        bit_cnt_next       = bit_cnt_reg;
        emit_idx_next      = emit_idx_reg;
        case (seq_reg)
            SEQ_ACCEPT: begin
                if (in_fire) begin
                    bit_cnt_next = 3'd0;
                    shift_next   = s_tdata;
                    case (frame_reg)
                        FR_TYPE: held_type_next = s_tdata;
                        FR_LEN: begin
                            if (len_ok) begin
                                held_length_next   = LEN_W'(s_tdata);
                                payload_count_next = '0;
                            end
                        end
                        FR_CRCLO:   received_crc_next[7:0]  = s_tdata;
                        FR_CRCHI:   received_crc_next[15:8] = s_tdata;
                        FR_PAYLOAD: payload_count_next = payload_count_reg + LEN_W'(1);
                        default: begin
                            if (is_sop) begin
                                running_crc_next = CRC_INIT;
                            end
                        end
                    endcase
                end
            end
            SEQ_CRC: begin
                running_crc_next = {1'b0, running_crc_reg[15:1]}
                                   ^ (crc_fb ? CRC_POLY_REFL : 16'h0000);
                shift_next       = {1'b0, shift_reg[7:1]};
                bit_cnt_next     = bit_cnt_reg + 3'd1;
            end
            SEQ_CHECK: begin
                payload_count_next = '0;
                emit_idx_next      = '0;
            end
            SEQ_SEND: begin
                if (out_fire && !out_last) begin
                    emit_idx_next = emit_idx_reg + IDX_W'(1);
                end
            end
            default: begin
                bit_cnt_next = bit_cnt_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg           <= SEQ_ACCEPT;
            frame_reg         <= FR_HUNT;
            held_type_reg     <= '0;
            held_length_reg   <= '0;
            received_crc_reg  <= '0;
            running_crc_reg   <= CRC_INIT;
            payload_count_reg <= '0;
        end else begin
            seq_reg           <= seq_next;
            frame_reg         <= frame_next;
            held_type_reg     <= held_type_next;
            held_length_reg   <= held_length_next;
            received_crc_reg  <= received_crc_next;
            running_crc_reg   <= running_crc_next;
            payload_count_reg <= payload_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg    <= shift_next;
        bit_cnt_reg  <= bit_cnt_next;
        emit_idx_reg <= emit_idx_next;
    end

    // Payload buffer: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            payload_mem[payload_count_reg[IDX_W-1:0]] <= s_tdata;
        end
        if (seq_reg == SEQ_READ) begin
            rd_data_reg <= payload_mem[emit_idx_reg];
        end
    end

    assign idx_wide   = 6'(emit_idx_reg);
    assign m_tdata    = {5'b0,
                         (has_payload ? rd_data_reg : 8'h00),
                         idx_wide[4:0],
                         6'(held_length_reg),
                         held_type_reg};
    assign m_tuser[0] = has_payload;
    assign m_tlast    = out_last;

endmodule

`default_nettype wire

// File: hw/rtl/cpd_checker.sv
// Port-level checker for the deframer, bound to the top level.
`default_nettype none
`include "crc16_packet_deframer_core_defines.svh"

module cpd_checker
    import cpd_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [0:0]           m_tuser,
    input wire logic                 m_tlast
);

    // Input is never taken while a result is on offer.
    `CPD_ASSERT_SAME(a_no_overlap, aclk, aresetn, m_tvalid, !s_tready, "ready while sending")

    // A stalled result holds its contents.
    `CPD_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

    // An empty packet is a single result with a zero payload byte.
    `CPD_ASSERT_SAME(a_empty, aclk, aresetn, m_tvalid && !m_tuser[0],
                     m_tlast && (m_tdata[26:19] == 8'h00), "bad empty result")

    // No result can follow an accepted byte in the very next cycle.
    `CPD_ASSERT_NEXT(a_in_gap, aclk, aresetn, s_tvalid && s_tready, !m_tvalid,
                     "result right after input")

    // Inside a run the block keeps input closed between results.
    `CPD_ASSERT_NEXT(a_run_closed, aclk, aresetn, m_tvalid && m_tready && !m_tlast,
                     !s_tready && !m_tvalid, "run interrupted")

endmodule

bind crc16_packet_deframer_core cpd_checker u_cpd_checker (.*);

`default_nettype wire

// File: tb/crc16_packet_deframer_core_tb.sv
// Self-checking testbench for the CRC-16 packet deframer core.
`default_nettype none

module crc16_packet_deframer_core_tb
    import cpd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 3000;
    localparam int RANDOM_ITEMS = 260;

    // One output transaction of an accepted packet.
    typedef struct {
        logic [7:0] ptype;
        logic [5:0] plen;
        logic [4:0] idx;
        logic [7:0] data;
        logic       has;
        logic       fin;
    } pkt_beat_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;   // [7:0] rx_byte
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [7:0] packet_type, [13:8] packet_length, [18:14] byte_index,
    // [26:19] payload_byte, [31:27] zero
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;   // [0] has_payload
    logic                 m_tlast;

    crc16_packet_deframer_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Deframer prediction state.
    frame_state_t fr_state;
    logic [7:0]   hdr_type;
    logic [5:0]   hdr_len;
    logic [15:0]  crc_recv;
    logic [15:0]  crc_run;
    logic [5:0]   pay_count;
    logic [7:0]   pay_store [DEF_MAX_PAYLOAD];
    pkt_beat_t    beats_due [$];

    int errors      = 0;
    int bytes_sent  = 0;
    int idle_cycles = 0;

    // Sender burst control.
    bit idle_on    = 1'b1;
    int burst_left = 0;

    // Receiver stall control; hold_seq is bumped by the tests only.
    int hold_len   = 0;
    int hold_seq   = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int rx_mode    = 0;
    int mode_left  = 0;
    int rx_phase   = 0;

    pkt_beat_t got;
    pkt_beat_t want;

    function automatic logic [15:0] crc16_mcrf_byte(input logic [15:0] crc,
                                                    input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
        return c;
    endfunction

    function automatic void release_packet();
        pkt_beat_t beat;
        if (crc_run == crc_recv) begin
            if (hdr_len == 6'd0) begin
                beat.ptype = hdr_type;
                beat.plen  = 6'd0;
                beat.idx   = 5'd0;
                beat.data  = 8'h00;
                beat.has   = 1'b0;
                beat.fin   = 1'b1;
                beats_due.push_back(beat);
            end else begin
                for (int i = 0; i < hdr_len && i < DEF_MAX_PAYLOAD; i++) begin
                    beat.ptype = hdr_type;
                    beat.plen  = hdr_len;
                    beat.idx   = i[4:0];
                    beat.data  = pay_store[i];
                    beat.has   = 1'b1;
                    beat.fin   = (i + 1 == hdr_len) || (i + 1 == DEF_MAX_PAYLOAD);
                    beats_due.push_back(beat);
                end
            end
        end
        fr_state  = FR_HUNT;
        pay_count = 6'd0;
    endfunction

    // Advances the predicted framer by one received byte.
    function automatic void deframe_byte(input logic [7:0] b);
        case (fr_state)
            FR_TYPE: begin
                hdr_type = b;
                crc_run  = crc16_mcrf_byte(crc_run, b);
                fr_state = FR_LEN;
            end
            FR_LEN: begin
                if (b <= DEF_MAX_PAYLOAD) begin
                    hdr_len   = b[5:0];
                    pay_count = 6'd0;
                    crc_run   = crc16_mcrf_byte(crc_run, b);
                    fr_state  = FR_CRCLO;
                end else begin
                    // An oversized length is not itself taken as a start byte.
                    fr_state = FR_HUNT;
                end
            end
            FR_CRCLO: begin
                crc_recv[7:0] = b;
                fr_state      = FR_CRCHI;
            end
            FR_CRCHI: begin
                crc_recv[15:8] = b;
                if (hdr_len == 6'd0)
                    release_packet();
                else
                    fr_state = FR_PAYLOAD;
            end
            FR_PAYLOAD: begin
                if (pay_count < DEF_MAX_PAYLOAD)
                    pay_store[pay_count[4:0]] = b;
                crc_run   = crc16_mcrf_byte(crc_run, b);
                pay_count = pay_count + 6'd1;
                if (pay_count >= hdr_len)
                    release_packet();
            end
            default: begin
                if (b == SOP_BYTE) begin
                    fr_state = FR_TYPE;
                    crc_run  = CRC_INIT;
                end else begin
                    fr_state = FR_HUNT;
                end
            end
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (idle_on) begin
            if (burst_left == 0) begin
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        do @(posedge aclk); while (!s_tready);
        deframe_byte(b);
        bytes_sent++;
        @(negedge aclk);
    endtask

    // A fill below zero gives random payload with the start byte mixed in.
    task automatic send_frame(input logic [7:0] ptype, input int len, input int fill,
                              input bit bad_crc);
        logic [7:0]  body [$];
        logic [15:0] crc;
        logic [7:0]  pb;
        crc = crc16_mcrf_byte(CRC_INIT, ptype);
        crc = crc16_mcrf_byte(crc, 8'(len));
        for (int i = 0; i < len; i++) begin
            if (fill >= 0)
                pb = 8'(fill);
            else if ($urandom_range(0, 15) == 0)
                pb = SOP_BYTE;
            else
                pb = 8'($urandom_range(0, 255));
            body.push_back(pb);
            crc = crc16_mcrf_byte(crc, pb);
        end
        if (bad_crc)
            crc = crc ^ (16'd1 << $urandom_range(0, 15));
        send_byte(SOP_BYTE);
        send_byte(ptype);
        send_byte(8'(len));
        send_byte(crc[7:0]);
        send_byte(crc[15:8]);
        foreach (body[i])
            send_byte(body[i]);
    endtask

    // The sender stops offering until every predicted transaction has been taken.
    task automatic wait_results_done();
        s_tvalid = 1'b0;
        while (beats_due.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic test_directed_cases();
        idle_on = 1'b0;
        send_frame(8'h00, 0, 0, 1'b0);
        send_frame(8'hFF, 1, 8'hFF, 1'b0);
        send_frame(SOP_BYTE, 1, SOP_BYTE, 1'b0);
        send_frame(8'h3C, 0, 0, 1'b1);
        // Length byte equal to the start byte, then one just above the maximum.
        send_byte(SOP_BYTE);
        send_byte(8'h10);
        send_byte(SOP_BYTE);
        send_byte(SOP_BYTE);
        send_byte(8'h22);
        send_byte(8'(DEF_MAX_PAYLOAD + 1));
        send_frame(8'h5A, 0, 0, 1'b0);
        wait_results_done();
    endtask

    // A long receiver hold-off lets the block fill and stall its input.
    task automatic test_backpressure();
        idle_on  = 1'b0;
        hold_len = 600;
        hold_seq++;
        send_frame(8'($urandom_range(0, 255)), DEF_MAX_PAYLOAD, -1, 1'b0);
        send_frame(8'($urandom_range(0, 255)), 5, -1, 1'b0);
        send_frame(8'($urandom_range(0, 255)), 0, 0, 1'b0);
        wait_results_done();
    endtask

    task automatic test_random_traffic();
        int start_count;
        int pick;
        int len;
        start_count = bytes_sent;
        while (bytes_sent - start_count < RANDOM_ITEMS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            pick    = $urandom_range(0, 19);
            len     = ($urandom_range(0, 9) == 0) ? $urandom_range(9, DEF_MAX_PAYLOAD)
                                                   : $urandom_range(0, 8);
            if (pick < 15) begin
                send_frame(8'($urandom_range(0, 255)), len, -1, 1'b0);
            end else if (pick < 17) begin
                send_frame(8'($urandom_range(0, 255)), len, -1, 1'b1);
            end else if (pick < 19) begin
                repeat ($urandom_range(1, 4))
                    send_byte(($urandom_range(0, 3) == 0) ? SOP_BYTE
                                                          : 8'($urandom_range(0, 255)));
            end else begin
                // Broken header with a length beyond the buffer.
                send_byte(SOP_BYTE);
                send_byte(8'($urandom_range(0, 255)));
                send_byte(8'($urandom_range(DEF_MAX_PAYLOAD + 1, 255)));
            end
        end
        wait_results_done();
    endtask

    // Receiver: random modes, including stretches with no stall at all.
    always @(negedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = hold_len;
        end
        if (mode_left == 0) begin
            rx_mode   = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        rx_phase++;
        if (hold_left != 0) begin
            hold_left--;
            m_tready = 1'b0;
        end else begin
            case (rx_mode)
                0:       m_tready = 1'b1;
                1:       m_tready = ($urandom_range(0, 3) != 0);
                default: m_tready = (rx_phase % 5 != 0) && (rx_phase % 7 != 3);
            endcase
        end
    end

    function automatic void check_field(input string name, input int exp_val,
                                        input int act_val);
        if (exp_val != act_val) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got.ptype = m_tdata[7:0];
            got.plen  = m_tdata[13:8];
            got.idx   = m_tdata[18:14];
            got.data  = m_tdata[26:19];
            got.has   = m_tuser[0];
            got.fin   = m_tlast;
            if (beats_due.size() == 0) begin
                $error("Unexpected output transaction: tdata 0x%0h", m_tdata);
                errors++;
            end else begin
                want = beats_due.pop_front();
                check_field("packet_type", want.ptype, got.ptype);
                check_field("packet_length", want.plen, got.plen);
                check_field("byte_index", want.idx, got.idx);
                check_field("payload_byte", want.data, got.data);
                check_field("has_payload", want.has, got.has);
                check_field("last", want.fin, got.fin);
            end
        end
    end

    // Watchdog on cycles in which neither side moves a transaction.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        fr_state  = FR_HUNT;
        hdr_type  = 8'h00;
        hdr_len   = 6'd0;
        crc_recv  = 16'h0000;
        crc_run   = CRC_INIT;
        pay_count = 6'd0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_directed_cases();
        test_backpressure();
        test_random_traffic();

        wait_results_done();
        repeat (40) @(posedge aclk);
        if (beats_due.size() != 0) begin
            $error("%0d expected transactions never arrived", beats_due.size());
            errors++;
        end
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
